// ===== hw/rtl/sitoa_pkg.sv =====
// sitoa_pkg: shared types and character codes for the signed integer to
// decimal text converter; no dependencies
package sitoa_pkg;

   localparam int CHAR_WIDTH = 7;
   localparam int BCD_WIDTH  = 4;

   typedef logic [CHAR_WIDTH-1:0] char_type;
   typedef logic [BCD_WIDTH-1:0]  bcd_type;

   localparam char_type SIGN_CHAR = 7'd45;
   localparam char_type ZERO_CHAR = 7'd48;
   localparam char_type NINE_CHAR = 7'd57;
   localparam bcd_type  BCD_ADJ_MIN = 4'd5;
   localparam bcd_type  BCD_ADJ     = 4'd3;

endpackage

// ===== hw/rtl/sitoa_if.sv =====
// sitoa_req_if / sitoa_rsp_if: valid/ready channels for the converter
// depends on sitoa_pkg
interface sitoa_req_if #(
   parameter int VALUE_WIDTH = 32
);
   logic                          valid;
   logic                          ready;
   logic signed [VALUE_WIDTH-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

interface sitoa_rsp_if
   import sitoa_pkg::*;
();
   logic     valid;
   logic     ready;
   char_type character;
   logic     last;

   modport source (output valid, output character, output last, input ready);
   modport sink   (input valid, input character, input last, output ready);
endinterface

// ===== hw/rtl/signed_int_to_decimal_ascii_top.sv =====
// signed_int_to_decimal_ascii_top: signed integer to decimal ascii text,
// bit-serial double dabble then one character per word; depends on
// sitoa_pkg and sitoa_if
//
//   channel    dir   word
//   req_chan   in    value, signed VALUE_WIDTH bits
//   rsp_chan   out   character (7 bits), last
//
// a taken value becomes its magnitude, runs the shift-and-add-3 bcd loop
// once per magnitude bit and drops leading zeros, then leaves
// one character per cycle (sign and digits) unless rsp_chan stalls
// req_chan.ready is high only between values; the final character may
// still sit in the output register while the next value is taken
// reset (synchronous, active high) clears the sequencer and output valid
module signed_int_to_decimal_ascii_top
   import sitoa_pkg::*;
#(
   parameter int VALUE_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   sitoa_req_if.sink   req_chan,
   sitoa_rsp_if.source rsp_chan
);

   localparam int DIGITS   = (3 * VALUE_WIDTH) / 10 + 2;
   localparam int BCD_BITS = DIGITS * BCD_WIDTH;
   localparam int BIT_CW   = $clog2(VALUE_WIDTH);
   localparam int DIG_CW   = $clog2(DIGITS + 1);
   localparam logic [BIT_CW-1:0] BIT_LAST = BIT_CW'(VALUE_WIDTH - 1);
   localparam logic [DIG_CW-1:0] DIG_ALL  = DIG_CW'(DIGITS);
   localparam logic [DIG_CW-1:0] DIG_ONE  = DIG_CW'(1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_SKIP,
      ST_SIGN,
      ST_DIGIT
   } state_type;

   state_type               state_ff;
   logic                    neg_ff;
   logic [VALUE_WIDTH-1:0]  mag_ff;
   logic [BCD_BITS-1:0]     bcd_ff;
   logic [BCD_BITS-1:0]     bcd_in;
   logic [BIT_CW-1:0]       bit_cnt_ff;
   logic [DIG_CW-1:0]       dig_cnt_ff;
   logic                    rsp_valid_ff;
   char_type                rsp_char_ff;
   logic                    rsp_last_ff;
   logic                    out_free;
   logic                    emit;
   bcd_type                 top_digit;

   assign req_chan.ready     = (state_ff == ST_IDLE);
   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.character = rsp_char_ff;
   assign rsp_chan.last      = rsp_last_ff;

   assign out_free  = !rsp_valid_ff || rsp_chan.ready;
   assign emit      = out_free && (state_ff == ST_SIGN || state_ff == ST_DIGIT);
   assign top_digit = bcd_ff[BCD_BITS-1 -: BCD_WIDTH];

   // add 3 to every digit of 5 or more, then shift in the next magnitude bit
   always_comb begin
      logic [BCD_BITS-1:0] adj;
      bcd_type             d;
      adj = '0;
      for (int i = 0; i < DIGITS; i++) begin
         d = bcd_ff[i*BCD_WIDTH +: BCD_WIDTH];
         adj[i*BCD_WIDTH +: BCD_WIDTH] = (d >= BCD_ADJ_MIN) ? d + BCD_ADJ : d;
      end
      bcd_in = {adj[BCD_BITS-2:0], mag_ff[VALUE_WIDTH-1]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_chan.valid) begin
                  neg_ff     <= req_chan.value[VALUE_WIDTH-1];
                  mag_ff     <= req_chan.value[VALUE_WIDTH-1] ?
                                (~req_chan.value + 1'b1) : req_chan.value;
                  bcd_ff     <= '0;
                  bit_cnt_ff <= '0;
                  dig_cnt_ff <= DIG_ALL;
                  state_ff   <= ST_CONVERT;
               end
            end
            ST_CONVERT: begin
               bcd_ff     <= bcd_in;
               mag_ff     <= {mag_ff[VALUE_WIDTH-2:0], 1'b0};
               bit_cnt_ff <= bit_cnt_ff + 1'b1;
               if (bit_cnt_ff == BIT_LAST) begin
                  state_ff <= ST_SKIP;
               end
            end
            ST_SKIP: begin
               if (top_digit == '0 && dig_cnt_ff != DIG_ONE) begin
                  bcd_ff     <= {bcd_ff[BCD_BITS-BCD_WIDTH-1:0], {BCD_WIDTH{1'b0}}};
                  dig_cnt_ff <= dig_cnt_ff - 1'b1;
               end else begin
                  state_ff <= neg_ff ? ST_SIGN : ST_DIGIT;
               end
            end
            ST_SIGN: begin
               if (out_free) begin
                  rsp_char_ff  <= SIGN_CHAR;
                  rsp_last_ff  <= 1'b0;
                  state_ff     <= ST_DIGIT;
               end
            end
            ST_DIGIT: begin
               if (out_free) begin
                  rsp_char_ff  <= ZERO_CHAR + {{(CHAR_WIDTH-BCD_WIDTH){1'b0}}, top_digit};
                  rsp_last_ff  <= (dig_cnt_ff == DIG_ONE);
                  bcd_ff       <= {bcd_ff[BCD_BITS-BCD_WIDTH-1:0], {BCD_WIDTH{1'b0}}};
                  dig_cnt_ff   <= dig_cnt_ff - 1'b1;
                  if (dig_cnt_ff == DIG_ONE) begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // only a sign or a decimal digit ever leaves
   a_char_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.character == SIGN_CHAR ||
         (rsp_chan.character >= ZERO_CHAR && rsp_chan.character <= NINE_CHAR)))
      else $error("illegal character on rsp_chan");

   // the sign never ends a number
   a_sign_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.character == SIGN_CHAR) |-> !rsp_chan.last)
      else $error("sign marked last");

   // a taken value keeps the block busy through the bcd loop
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> (!req_chan.ready && state_ff == ST_CONVERT))
      else $error("input not blocked after accept");

   // digit emission always has a digit left
   a_digit_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIGIT) |-> (dig_cnt_ff != '0))
      else $error("digit count ran out");

endmodule

// ===== tb/tb_top.sv =====
// tb_top: self-checking bench for the signed integer to decimal text converter;
// predicts the character words of every value taken and compares them in order
// depends on sitoa_pkg, sitoa_if and signed_int_to_decimal_ascii_top
module tb_top
   import sitoa_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int VALUE_WIDTH = 32;
   localparam int STALL_PCT   = 36;
   localparam int QUIET_LIMIT = 4000;
   localparam int TAIL_CYCLES = 80;

   typedef struct packed {
      char_type character;
      logic     last;
   } text_char_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   sitoa_req_if #(.VALUE_WIDTH(VALUE_WIDTH)) req_bus ();
   sitoa_rsp_if rsp_bus ();

   signed_int_to_decimal_ascii_top #(.VALUE_WIDTH(VALUE_WIDTH)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   text_char_type expected_text[$];
   bit         stall_free = 1'b0;
   int         mismatches = 0;
   int         values_taken = 0;
   int         negatives_taken = 0;
   int         chars_checked = 0;
   int         quiet_cycles = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic void predict_text(input logic [VALUE_WIDTH-1:0] v);
      logic [VALUE_WIDTH-1:0] magnitude;
      char_type               digits[$];
      magnitude = v[VALUE_WIDTH-1] ? (~v + 1'b1) : v;
      if (v[VALUE_WIDTH-1]) begin
         expected_text.push_back('{SIGN_CHAR, 1'b0});
      end
      do begin
         digits.push_front(ZERO_CHAR + char_type'(magnitude % 10));
         magnitude = magnitude / 10;
      end while (magnitude != 0);
      foreach (digits[i]) begin
         expected_text.push_back('{digits[i], i == digits.size() - 1});
      end
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
      mismatches++;
   endtask

   // receiver side: random stalls unless running stall free
   always @(negedge clock) begin
      rsp_bus.ready <= stall_free || ($urandom_range(99) >= STALL_PCT);
   end

   // monitor, checker and watchdog
   always @(posedge clock) begin
      text_char_type want;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            predict_text(req_bus.value);
            values_taken++;
            if (req_bus.value[VALUE_WIDTH-1]) negatives_taken++;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            chars_checked++;
            if (expected_text.size() == 0) begin
               report_mismatch("unexpected character", rsp_bus.character, 0);
            end else begin
               want = expected_text.pop_front();
               if (rsp_bus.character !== want.character)
                  report_mismatch("character", rsp_bus.character, want.character);
               if (rsp_bus.last !== want.last)
                  report_mismatch("last", rsp_bus.last, want.last);
            end
         end
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: no word moved for %0d cycles", QUIET_LIMIT);
            $display("simulation failed");
            $finish;
         end
      end
   end

   task automatic send_value(input logic signed [VALUE_WIDTH-1:0] v);
      while (!stall_free && $urandom_range(99) < STALL_PCT) @(negedge clock);
      req_bus.valid = 1'b1;
      req_bus.value = v;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
      req_bus.valid = 1'b0;
   endtask

   task automatic wait_drained;
      while (expected_text.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic logic signed [VALUE_WIDTH-1:0] random_value;
      longint unsigned span;
      int              ndigits;
      logic signed [VALUE_WIDTH-1:0] v;
      if ($urandom_range(2) == 0) begin
         v = $urandom;
      end else begin
         ndigits = $urandom_range(1, 10);
         span = 1;
         repeat (ndigits) span = span * 10;
         v = VALUE_WIDTH'({$urandom, $urandom} % span);
         if ($urandom_range(1)) v = -v;
      end
      return v;
   endfunction

   task automatic test_extremes;
      logic signed [VALUE_WIDTH-1:0] corner[$];
      corner = {0, 1, -1, 9, -9, 10, -10, 99, 100, -100, 12345, -67890,
                999999999, 1000000000, -999999999, -1000000000,
                32'sh7fffffff, 32'sh80000000, 32'sh80000001, 32'sh7ffffffe,
                32'sh55555555, 32'shaaaaaaaa, 2000000000, -2147483647};
      foreach (corner[i]) send_value(corner[i]);
   endtask

   task automatic test_back_to_back;
      stall_free = 1'b1;
      repeat (45) send_value(random_value());
      wait_drained();
      stall_free = 1'b0;
   endtask

   task automatic test_random_values;
      for (int i = 0; i < 140; i++) begin
         send_value(random_value());
         if (i == 70) wait_drained();
      end
   endtask

   initial begin
      req_bus.valid = 1'b0;
      req_bus.value = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_extremes();
      test_back_to_back();
      test_random_values();

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (expected_text.size() != 0)
         report_mismatch("characters never arrived", 0, expected_text.size());

      $display("converted %0d values, %0d of them negative, extremes and zero included",
               values_taken, negatives_taken);
      $display("checked %0d characters, %0d mismatches", chars_checked, mismatches);
      if (mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
